[src/dyuvd_pkg.sv]
// Shared types and constants of the DYUV delta pixel decoder.
`default_nettype none
package dyuvd_pkg;

	localparam logic [31:0] DQ_RESET_0 = 32'h0904_0100;
	localparam logic [31:0] DQ_RESET_1 = 32'h4F2C_1B10;
	localparam logic [31:0] DQ_RESET_2 = 32'hE5D4_B180;
	localparam logic [31:0] DQ_RESET_3 = 32'hFFFC_F7F0;

	localparam logic signed [18:0] COEF_RV = 19'sd351;
	localparam logic signed [18:0] COEF_GU = 19'sd86;
	localparam logic signed [18:0] COEF_GV = 19'sd179;
	localparam logic signed [18:0] COEF_BU = 19'sd444;
	localparam logic signed [8:0]  CHROMA_BIAS = 9'sd128;
	localparam logic signed [18:0] ROUND_NEG = 19'sd255;

	typedef struct packed {
		logic [3:0][31:0] dq_table;
		logic             duplicate;
	} cfg_t;

	typedef struct packed {
		logic [7:0] y;
		logic [7:0] u;
		logic [7:0] v;
	} yuv_t;

	typedef struct packed {
		yuv_t p1;
		yuv_t p2;
		logic duplicate;
	} pair_t;

endpackage
`default_nettype wire

[src/dyuvd_front.sv]
// Front end: accepts byte pairs, updates the predictors and queues both pixels in YUV.
`default_nettype none
module dyuvd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dyuvd_pkg::cfg_t   cfg,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [39:0]       s_tdata,
	input  wire logic              s_tuser,
	input  wire logic              q_full,
	output logic                   q_push,
	output dyuvd_pkg::pair_t       q_data
);
	import dyuvd_pkg::*;

	function automatic logic [7:0] dq(input logic [3:0][31:0] tbl, input logic [3:0] code);
		logic [31:0] word;
		word = tbl[code[3:2]];
		return word[{code[1:0], 3'b000} +: 8];
	endfunction

	logic [7:0] luma_q, u_q, v_q;
	logic [7:0] py, pu, pv, hi, lo;
	logic [7:0] y1, y2, u2, v2;
	logic [8:0] u_sum, v_sum;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;
	assign hi       = s_tdata[31:24];
	assign lo       = s_tdata[39:32];

	always_comb begin
		py    = s_tuser ? s_tdata[7:0]   : luma_q;
		pu    = s_tuser ? s_tdata[15:8]  : u_q;
		pv    = s_tuser ? s_tdata[23:16] : v_q;
		y1    = py + dq(cfg.dq_table, hi[3:0]);
		u2    = pu + dq(cfg.dq_table, hi[7:4]);
		v2    = pv + dq(cfg.dq_table, lo[7:4]);
		y2    = y1 + dq(cfg.dq_table, lo[3:0]);
		u_sum = {1'b0, pu} + {1'b0, u2};
		v_sum = {1'b0, pv} + {1'b0, v2};
		q_data.p1.y      = y1;
		q_data.p1.u      = u_sum[8:1];
		q_data.p1.v      = v_sum[8:1];
		q_data.p2.y      = y2;
		q_data.p2.u      = u2;
		q_data.p2.v      = v2;
		q_data.duplicate = cfg.duplicate;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_q <= '0;
			u_q    <= '0;
			v_q    <= '0;
		end else if (q_push) begin
			luma_q <= y2;
			u_q    <= u2;
			v_q    <= v2;
		end
	end

endmodule
`default_nettype wire

[src/dyuvd_fifo.sv]
// Short queue of decoded pixel pairs between front and back end.
`default_nettype none
module dyuvd_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire dyuvd_pkg::pair_t push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output dyuvd_pkg::pair_t      head_data
);
	import dyuvd_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pair_t         entries_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_data  = entries_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[src/dyuvd_back.sv]
// Back end: matrixes queued pixels to RGB and drives the output register.
`default_nettype none
module dyuvd_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire dyuvd_pkg::pair_t head_data,
	output logic                  pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [23:0]           m_tdata,
	output logic                  m_tlast
);
	import dyuvd_pkg::*;

	function automatic logic signed [10:0] div256(input logic signed [18:0] p);
		logic signed [18:0] t;
		t = p + ((p < 0) ? ROUND_NEG : 19'sd0);
		return t[18:8];
	endfunction

	function automatic logic [7:0] clamp_byte(input logic signed [10:0] x);
		logic [7:0] res;
		if (x < 0) begin
			res = 8'd0;
		end else if (x > 11'sd255) begin
			res = 8'd255;
		end else begin
			res = x[7:0];
		end
		return res;
	endfunction

	logic [1:0]         idx_q;
	logic               out_valid_q, last_q;
	logic [23:0]        rgb_q;
	logic               sel_p2, is_last, load;
	yuv_t               pix;
	logic signed [18:0] uu, vv;
	logic signed [10:0] yy, r, g, b;
	logic [23:0]        rgb;

	always_comb begin
		sel_p2  = head_data.duplicate ? idx_q[1] : idx_q[0];
		is_last = head_data.duplicate ? (idx_q == 2'd3) : (idx_q == 2'd1);
		load    = head_valid && (!out_valid_q || m_tready);
		pop     = load && is_last;
		pix     = sel_p2 ? head_data.p2 : head_data.p1;
		yy      = $signed({3'b000, pix.y});
		uu      = 19'($signed({1'b0, pix.u}) - CHROMA_BIAS);
		vv      = 19'($signed({1'b0, pix.v}) - CHROMA_BIAS);
		r       = yy + div256(vv * COEF_RV);
		g       = yy - div256(uu * COEF_GU + vv * COEF_GV);
		b       = yy + div256(uu * COEF_BU);
		rgb     = {clamp_byte(b), clamp_byte(g), clamp_byte(r)};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rgb_q  <= rgb;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = rgb_q;
	assign m_tlast  = last_q;

endmodule
`default_nettype wire

[src/dyuv_delta_pixel_decoder.sv]
// Top level of the DYUV delta pixel decoder with its register port.
// Usage:
//   Slave stream: one DYUV byte pair per request; s_tuser set loads the Y, U and V
//   predictors from the initial fields before the pair is decoded.
//   Master stream: one RGB pixel per request; m_tlast marks the final pixel of a pair.
//   Each pair gives two pixels, or four (each pixel twice) with duplicate_pixels set.
//   Register port: dequantizer table words at 0x00..0x0C, duplicate flag at 0x10.
// Path: a pair taken is written into the pair queue; its first pixel is offered from the
//   output register once the pair reaches the queue head. Throughput: set by the output
//   register, which sends one pixel per cycle while m_tready is high; the front end takes
//   a pair every cycle while the pair queue has room.
// Reset: predictors clear to zero, the table and duplicate flag take their defaults,
//   the queue empties and no pixel is offered.
// Stall: a low m_tready keeps the pending pixel stable; the queue fills and then
//   s_tready drops until pixels drain.
`default_nettype none
module dyuv_delta_pixel_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // initial_y, initial_u, initial_v, high_byte, low_byte
	input  wire logic        s_tuser,  // line_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // red, green, blue
	output logic             m_tlast
);
	import dyuvd_pkg::*;

	localparam logic [2:0] REG_DQ_0_3   = 3'd0;
	localparam logic [2:0] REG_DQ_4_7   = 3'd1;
	localparam logic [2:0] REG_DQ_8_11  = 3'd2;
	localparam logic [2:0] REG_DQ_12_15 = 3'd3;
	localparam logic [2:0] REG_DUP      = 3'd4;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;
	logic       q_push, q_full, q_pop, q_valid;
	pair_t      q_in, q_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dq_table[0] <= DQ_RESET_0;
			cfg_q.dq_table[1] <= DQ_RESET_1;
			cfg_q.dq_table[2] <= DQ_RESET_2;
			cfg_q.dq_table[3] <= DQ_RESET_3;
			cfg_q.duplicate   <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DQ_0_3:   cfg_q.dq_table[0] <= pwdata;
				REG_DQ_4_7:   cfg_q.dq_table[1] <= pwdata;
				REG_DQ_8_11:  cfg_q.dq_table[2] <= pwdata;
				REG_DQ_12_15: cfg_q.dq_table[3] <= pwdata;
				REG_DUP:      cfg_q.duplicate   <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DQ_0_3:   prdata = cfg_q.dq_table[0];
			REG_DQ_4_7:   prdata = cfg_q.dq_table[1];
			REG_DQ_8_11:  prdata = cfg_q.dq_table[2];
			REG_DQ_12_15: prdata = cfg_q.dq_table[3];
			REG_DUP:      prdata = {31'd0, cfg_q.duplicate};
			default:      prdata = 32'd0;
		endcase
	end

	dyuvd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	dyuvd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_head)
	);

	dyuvd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_data  (q_head),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire
